@@ rtl/rbgs_pkg.sv @@
// Shared types and constants for the red-black Gauss-Seidel 1D smoother.
// Used by rbgs_ctrl, rbgs_datapath and the top level red_black_gauss_seidel_1d.
`timescale 1ns / 1ps

package rbgs_pkg;

  localparam int VAL_W   = 48;
  localparam int RHS_W   = 47;
  localparam int IDX_W   = 10;
  localparam int VLEN_W  = 11;
  localparam int SWEEP_W = 16;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 56;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHS_SCALED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT   = 2'd2;

  localparam logic [VLEN_W-1:0]  VLEN_RESET  = 11'd100;
  localparam logic [SWEEP_W-1:0] SWEEP_RESET = 16'd1;

  localparam logic [VAL_W-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_RANGE = 2'd1,
    RES_READ  = 2'd2,
    RES_SWEEP = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      load_wr;
    logic      rd_issue;
    logic      res_set;
    res_kind_t res_kind;
    logic      sw_init;
    logic      issue;
    logic      phase_next;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       sweep_zero;
    logic       phase_last;
    logic       sweep_last;
  } stat_t;

endpackage

@@ rtl/red_black_gauss_seidel_1d.sv @@
// Red-black Gauss-Seidel 1D Poisson smoother: load, read and in-place sweeps.
// Sweeps handle one entry per cycle through the two-read-port store, with one
// drain state per half sweep.
// One operation at a time; next input taken once the result is queued.
// Reset (rst, synchronous): control and config registers; store contents stay undefined.
`timescale 1ns / 1ps

module red_black_gauss_seidel_1d
  import rbgs_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] operation, [11:2] element_index, [59:12] element_value, [63:60] zero
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [47:0] read_value, [49:48] status, [55:50] zero
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RHS_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  rbgs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  rbgs_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ rtl/rbgs_datapath.sv @@
// Datapath: configuration registers, solution store, sweep counters,
// relaxation pipeline and result/output registers. Depends on rbgs_pkg.
`timescale 1ns / 1ps

module rbgs_datapath
  import rbgs_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RHS_W-1:0]     cfg_data,
  input  logic [IN_W-1:0]      in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [OUT_W-1:0]     out_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int NW = (AW + 1 > VLEN_W) ? AW + 1 : VLEN_W;

  logic [VLEN_W-1:0]  vector_length;
  logic [RHS_W-1:0]   rhs_scaled;
  logic [SWEEP_W-1:0] sweep_count;

  logic [1:0]       in_op;
  logic [IDX_W-1:0] in_idx;
  logic [VAL_W-1:0] in_val;
  logic [NW-1:0]    in_idx_ext;
  logic [NW-1:0]    vl_ext;
  logic [NW-1:0]    len_n;
  logic             in_range;

  logic [NW-1:0]      elem_i;
  logic               phase;
  logic [SWEEP_W-1:0] sweeps_left;
  logic [NW:0]        i_plus2;
  logic [NW-1:0]      left_addr;
  logic [NW-1:0]      right_addr;

  logic [VAL_W-1:0] store [MAX_LEN];
  logic [AW-1:0]    ra_addr;
  logic [AW-1:0]    rb_addr;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             mem_we;
  logic [VAL_W-1:0] q_a;
  logic [VAL_W-1:0] q_b;

  logic             vld1;
  logic [NW-1:0]    idx1;
  logic             left_ok;
  logic             right_ok;
  logic [NW:0]      idx1_plus1;
  logic [VAL_W-1:0] left_v;
  logic [VAL_W-1:0] right_v;
  logic [VAL_W+1:0] sum;
  logic             ovf;
  logic [VAL_W-1:0] clip;
  logic [VAL_W-1:0] relaxed;
  logic             sat;

  logic [VAL_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;
  logic [VAL_W-1:0]  out_value;
  logic [STAT_W-1:0] out_status;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
      rhs_scaled    <= '0;
      sweep_count   <= SWEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH: vector_length <= cfg_data[VLEN_W-1:0];
        CFG_RHS_SCALED:    rhs_scaled    <= cfg_data;
        CFG_SWEEP_COUNT:   sweep_count   <= cfg_data[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields and active length
  assign in_op      = in_data[1:0];
  assign in_idx     = in_data[IDX_W+1:2];
  assign in_val     = in_data[IDX_W+VAL_W+1:IDX_W+2];
  assign in_idx_ext = NW'(in_idx);
  assign vl_ext     = NW'(vector_length);

  always_comb begin
    if (vl_ext < NW'(2)) begin
      len_n = NW'(2);
    end else if (vl_ext > NW'(MAX_LEN)) begin
      len_n = NW'(MAX_LEN);
    end else begin
      len_n = vl_ext;
    end
  end

  assign in_range = in_idx_ext < len_n;

  // sweep position: phase 0 updates even entries, phase 1 odd entries
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_i      <= '0;
      phase       <= 1'b0;
      sweeps_left <= '0;
    end else if (cmd.sw_init) begin
      elem_i      <= '0;
      phase       <= 1'b0;
      sweeps_left <= sweep_count;
    end else if (cmd.phase_next) begin
      if (phase) begin
        elem_i      <= '0;
        phase       <= 1'b0;
        sweeps_left <= sweeps_left - SWEEP_W'(1);
      end else begin
        elem_i <= NW'(1);
        phase  <= 1'b1;
      end
    end else if (cmd.issue) begin
      elem_i <= i_plus2[NW-1:0];
    end
  end

  assign i_plus2    = {1'b0, elem_i} + (NW + 1)'(2);
  assign left_addr  = elem_i - NW'(1);
  assign right_addr = elem_i + NW'(1);

  // solution store: one write port, two registered read ports
  assign ra_addr = cmd.issue ? left_addr[AW-1:0] : in_idx_ext[AW-1:0];
  assign rb_addr = right_addr[AW-1:0];
  assign mem_we  = vld1 | (cmd.load_wr & in_range);
  assign wr_addr = vld1 ? idx1[AW-1:0] : in_idx_ext[AW-1:0];
  assign wr_data = vld1 ? relaxed : in_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.issue || cmd.rd_issue) begin
      q_a <= store[ra_addr];
      q_b <= store[rb_addr];
    end
  end

  // relaxation stage, aligned with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      idx1 <= elem_i;
    end
  end

  assign idx1_plus1 = {1'b0, idx1} + (NW + 1)'(1);
  assign left_ok    = idx1 != '0;
  assign right_ok   = idx1_plus1 < {1'b0, len_n};
  assign left_v     = left_ok ? q_a : '0;
  assign right_v    = right_ok ? q_b : '0;

  assign sum = {3'b000, rhs_scaled}
             + {{2{left_v[VAL_W-1]}}, left_v}
             + {{2{right_v[VAL_W-1]}}, right_v};

  assign ovf     = (sum[VAL_W+1] != sum[VAL_W]) || (sum[VAL_W] != sum[VAL_W-1]);
  assign clip    = ovf ? (sum[VAL_W+1] ? Q_MIN : Q_MAX) : sum[VAL_W-1:0];
  assign relaxed = {clip[VAL_W-1], clip[VAL_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (cmd.sw_init) begin
      sat <= 1'b0;
    end else if (vld1 && ovf) begin
      sat <= 1'b1;
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res_kind)
        RES_OK: begin
          res_value  <= '0;
          res_status <= ST_OK;
        end
        RES_RANGE: begin
          res_value  <= '0;
          res_status <= ST_RANGE;
        end
        RES_READ: begin
          res_value  <= q_a;
          res_status <= ST_OK;
        end
        RES_SWEEP: begin
          res_value  <= '0;
          res_status <= sat ? ST_SAT : ST_OK;
        end
        default: begin
          res_value  <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign out_data = {(OUT_W - VAL_W - STAT_W)'(0), out_status, out_value};

  assign stat.op         = in_op;
  assign stat.in_range   = in_range;
  assign stat.sweep_zero = sweep_count == '0;
  assign stat.phase_last = i_plus2 >= {1'b0, len_n};
  assign stat.sweep_last = phase && (sweeps_left == SWEEP_W'(1));

endmodule

@@ rtl/rbgs_ctrl.sv @@
// Controller state machine: input handshake, operation sequencing, sweep
// phase control and output valid. Depends on rbgs_pkg.
`timescale 1ns / 1ps

module rbgs_ctrl
  import rbgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  output logic  m_axis_tvalid,
  input  logic  m_axis_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_SWEEP  = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_DONE   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   take;
  logic   out_free;

  assign s_axis_tready = state == S_IDLE;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_kind = RES_OK;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (stat.op)
            OP_LOAD: begin
              cmd.load_wr  = stat.in_range;
              cmd.res_set  = 1'b1;
              cmd.res_kind = stat.in_range ? RES_OK : RES_RANGE;
              state_next   = S_RESP;
            end
            OP_READ: begin
              if (stat.in_range) begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RDWAIT;
              end else begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_RANGE;
                state_next   = S_RESP;
              end
            end
            OP_SWEEP: begin
              if (stat.sweep_zero) begin
                cmd.res_set = 1'b1;
                state_next  = S_RESP;
              end else begin
                cmd.sw_init = 1'b1;
                state_next  = S_SWEEP;
              end
            end
            default: begin
              cmd.res_set = 1'b1;
              state_next  = S_RESP;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.res_set  = 1'b1;
        cmd.res_kind = RES_READ;
        state_next   = S_RESP;
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (stat.phase_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last write of the phase lands at the end of this cycle
        if (stat.sweep_last) begin
          state_next = S_DONE;
        end else begin
          cmd.phase_next = 1'b1;
          state_next     = S_SWEEP;
        end
      end
      S_DONE: begin
        cmd.res_set  = 1'b1;
        cmd.res_kind = RES_SWEEP;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;

`ifndef SYNTHESIS
  a_load_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> stat.in_range)
    else $error("store write for an index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_axis_tready))
    else $error("pending result overwritten");

  a_sweep_stays: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && !stat.phase_last) |=> state == S_SWEEP)
    else $error("sweep phase left early");

  a_drain_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |=> (state == S_SWEEP || state == S_DONE))
    else $error("bad exit from drain");
`endif

endmodule
